// File: rtl/sm4_pkg.sv
// sm4_pkg: shared types, constants and round functions of the sm4 block encryptor
// used by the channel interfaces and by sm4_block_encrypt; no dependencies

package sm4_pkg;

    localparam int SM4_ROUNDS = 32;
    localparam int RK_ADDR_W  = $clog2(SM4_ROUNDS);
    localparam int RK_W       = 32;

    // request function codes
    localparam logic FUNC_LOAD_KEY = 1'b0;
    localparam logic FUNC_ENCRYPT  = 1'b1;

    // request payload
    typedef struct packed {
        logic        func;
        logic [4:0]  key_slot;
        logic [31:0] round_key_word;
        logic [63:0] plain_high;
        logic [63:0] plain_low;
    } cmd_item_t;

    // result payload
    typedef struct packed {
        logic [63:0] cipher_high;
        logic [63:0] cipher_low;
    } res_item_t;

    // standard sm4 s-box
    localparam logic [7:0] SM4_SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    // byte-wise s-box substitution of one word
    function automatic logic [31:0] sm4_tau(input logic [31:0] v);
        sm4_tau = {SM4_SBOX[v[31:24]], SM4_SBOX[v[23:16]],
                   SM4_SBOX[v[15:8]],  SM4_SBOX[v[7:0]]};
    endfunction

    // linear rotate-xor mix
    function automatic logic [31:0] sm4_mix(input logic [31:0] b);
        sm4_mix = b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]}
                    ^ {b[13:0], b[31:14]} ^ {b[7:0], b[31:8]};
    endfunction

endpackage

// File: rtl/sm4_if.sv
// sm4_if: valid/ready channel interfaces for requests and results
// depends on sm4_pkg for the payload types

interface sm4_cmd_if;
    logic               valid;
    logic               ready;
    sm4_pkg::cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sm4_res_if;
    logic               valid;
    logic               ready;
    sm4_pkg::res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/sm4_ram.sv
// sm4_ram: generic single-write, single-read ram with registered read data
// no dependencies

module sm4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/sm4_block_encrypt.sv
// sm4_block_encrypt: sm4 block encryption with a loaded table of round keys
// depends on sm4_pkg, sm4_if (sm4_cmd_if, sm4_res_if) and sm4_ram

// A key-load request (func 0) writes one round key into the key ram and
// gives no result. For an encrypt request (func 1), one shared round unit
// (xor, four s-box lookups and the rotate-xor mix) does one of the 32
// rounds per clock, fed by the key ram whose registered read is fetched one
// round ahead. The ciphertext lands in an output register, so a new request
// is taken while a result still waits; if that register is still full when
// the last round ends, the block waits in its done state until the register
// is free before it is ready again. All round keys an encrypt uses must be
// loaded first; the key ram has no reset.

module sm4_block_encrypt (
    input  logic         clk,
    input  logic         rst_n,
    sm4_cmd_if.sink      cmd,
    sm4_res_if.source    result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [sm4_pkg::RK_ADDR_W-1:0] LAST_ROUND =
        sm4_pkg::RK_ADDR_W'(sm4_pkg::SM4_ROUNDS - 1);

    logic [1:0]                      state_reg, state_next;
    logic [sm4_pkg::RK_ADDR_W-1:0]   round_reg, round_next;
    logic [31:0]                     w0_reg, w1_reg, w2_reg, w3_reg;
    logic [31:0]                     w0_next, w1_next, w2_next, w3_next;
    logic                            res_valid_reg, res_valid_next;
    sm4_pkg::res_item_t              res_data_reg, res_data_next;

    logic                            cmd_fire;
    logic                            key_we;
    logic [sm4_pkg::RK_ADDR_W-1:0]   key_raddr;
    logic [sm4_pkg::RK_W-1:0]        round_key;
    logic [31:0]                     new_word;
    logic                            res_free;

    assign cmd.ready    = (state_reg == ST_IDLE);
    assign cmd_fire     = cmd.valid && cmd.ready;
    assign key_we       = cmd_fire && (cmd.data.func == sm4_pkg::FUNC_LOAD_KEY);
    assign res_free     = !res_valid_reg || result.ready;
    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    // key fetch runs one round ahead of the round unit
    assign key_raddr = (state_reg == ST_RUN) ?
                       sm4_pkg::RK_ADDR_W'(round_reg + 1'b1) : '0;

    sm4_ram #(
        .WIDTH (sm4_pkg::RK_W),
        .DEPTH (sm4_pkg::SM4_ROUNDS)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (cmd.data.key_slot),
        .wdata (cmd.data.round_key_word),
        .raddr (key_raddr),
        .rdata (round_key)
    );

    // shared round unit
    assign new_word = w0_reg ^ sm4_pkg::sm4_mix(
                          sm4_pkg::sm4_tau(w1_reg ^ w2_reg ^ w3_reg ^ round_key));

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        round_next     = round_reg;
        w0_next        = w0_reg;
        w1_next        = w1_reg;
        w2_next        = w2_reg;
        w3_next        = w3_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_data_next  = res_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && (cmd.data.func == sm4_pkg::FUNC_ENCRYPT))
                begin
                    w0_next    = cmd.data.plain_high[63:32];
                    w1_next    = cmd.data.plain_high[31:0];
                    w2_next    = cmd.data.plain_low[63:32];
                    w3_next    = cmd.data.plain_low[31:0];
                    round_next = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                w0_next    = w1_reg;
                w1_next    = w2_reg;
                w2_next    = w3_reg;
                w3_next    = new_word;
                round_next = sm4_pkg::RK_ADDR_W'(round_reg + 1'b1);
                if (round_reg == LAST_ROUND)
                begin
                    if (res_free)
                    begin
                        res_valid_next = 1'b1;
                        res_data_next  = '{cipher_high: {new_word, w3_reg},
                                           cipher_low:  {w2_reg, w1_reg}};
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // words hold x32..x35, waiting for the output register
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_data_next  = '{cipher_high: {w3_reg, w2_reg},
                                       cipher_low:  {w1_reg, w0_reg}};
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            round_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            round_reg     <= round_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        w2_reg       <= w2_next;
        w3_reg       <= w3_next;
        res_data_reg <= res_data_next;
    end

`ifndef SYNTHESIS
    // an encrypt request starts the rounds at round zero
    a_start_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && (cmd.data.func == sm4_pkg::FUNC_ENCRYPT)
        |=> (state_reg == ST_RUN) && (round_reg == '0))
        else $error("encrypt request did not start the round sequence");

    // rounds advance by one each cycle
    a_round_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) && (round_reg != LAST_ROUND)
        |=> (state_reg == ST_RUN) && (round_reg == $past(round_reg) + 1'b1))
        else $error("round counter skipped or run ended early");

    // a fresh result only follows the last round or the wait state
    a_result_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg)
        |-> ($past(state_reg) == ST_RUN && $past(round_reg) == LAST_ROUND)
            || ($past(state_reg) == ST_DONE))
        else $error("result appeared before the rounds finished");

    // a pending result is never overwritten before it is taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !result.ready |=> res_valid_reg && $stable(res_data_reg))
        else $error("stalled result changed");
`endif

endmodule
